// ----- src/pts_pkg.sv -----
// Shared types and constants for the pass topological sort and cull block.
// No dependencies; used by pts_ctrl, pts_datapath and the top level.
package pts_pkg;

  localparam int SLOTS          = 32;
  localparam int MAX_PASSES_DEF = 32;
  localparam int IDX_W          = 5;
  localparam int CNT_W          = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CYCLE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MASK,
    S_SEED,
    S_DRAIN,
    S_POP,
    S_LIVE_INIT,
    S_LIVE,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic load;       // write accepted request into the row store
    logic mask;       // drop self and out-of-range dependency bits
    logic seed;       // release vector = passes with no dependencies
    logic enq;        // push lowest released pass into the ready queue
    logic pop;        // take queue head, place it, release successors
    logic live_init;  // alive = output writers
    logic live_step;  // one backward propagation sweep
    logic emit_sort;  // load next sorted result into the output register
    logic emit_err;   // load cycle or overflow result
    logic clear;      // empty the graph for the next load
  } cmd_t;

  typedef struct packed {
    logic ovf_now;     // this request overflows or overflow already flagged
    logic rel_empty;
    logic queue_empty;
    logic all_placed;
    logic alive_changed;
    logic emit_done;   // the current sorted result is the final one
    logic out_free;    // output register can take a new result
  } stat_t;

endpackage

// ----- src/pts_ctrl.sv -----
// Sequencer for load, sort, cull and emit phases.
// Depends on pts_pkg; drives pts_datapath through cmd_t, reads stat_t.
module pts_ctrl
  import pts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  input  stat_t st,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid && in_last) begin
          state_next = st.ovf_now ? S_ERR : S_MASK;
        end
      end
      S_MASK:      state_next = S_SEED;
      S_SEED:      state_next = S_DRAIN;
      S_DRAIN: begin
        if (st.rel_empty) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (st.queue_empty) begin
          state_next = st.all_placed ? S_LIVE_INIT : S_ERR;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_LIVE_INIT: state_next = S_LIVE;
      S_LIVE: begin
        if (!st.alive_changed) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free && st.emit_done) begin
          state_next = S_LOAD;
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MASK:      cmd.mask = 1'b1;
      S_SEED:      cmd.seed = 1'b1;
      S_DRAIN:     cmd.enq  = !st.rel_empty;
      S_POP:       cmd.pop  = !st.queue_empty;
      S_LIVE_INIT: cmd.live_init = 1'b1;
      S_LIVE:      cmd.live_step = 1'b1;
      S_EMIT: begin
        cmd.emit_sort = st.out_free;
        cmd.clear     = st.out_free && st.emit_done;
      end
      S_ERR: begin
        cmd.emit_err = st.out_free;
        cmd.clear    = st.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/pts_datapath.sv -----
// Row store, ready queue, execution order, liveness and output register.
// Depends on pts_pkg; commanded by pts_ctrl.
module pts_datapath
  import pts_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [SLOTS-1:0]    in_mask,
  input  logic                in_wout,
  input  logic                out_ready,
  output stat_t               st,
  output logic                out_valid,
  output status_t             out_status,
  output logic [IDX_W-1:0]    out_idx,
  output logic [IDX_W-1:0]    out_pos,
  output logic                out_culled,
  output logic [CNT_W-1:0]    out_count,
  output logic                out_last
);

  localparam int CAP = (MAX_PASSES < SLOTS) ? MAX_PASSES : SLOTS;

  logic [SLOTS-1:0] rows [SLOTS];
  logic [IDX_W-1:0] queue [SLOTS];
  logic [IDX_W-1:0] order [SLOTS];

  logic [SLOTS-1:0] writers, alive, placed_set, rel, valid;
  logic [CNT_W-1:0] cnt, placed, head, tail;
  logic             overflow;
  logic [IDX_W-1:0] k;

  logic [IDX_W-1:0] cur, low_idx;
  logic [SLOTS-1:0] placed_next, pop_rel, seed_rel, live_or;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      valid[i] = (CNT_W'(i) < cnt);
    end
  end

  assign cur         = queue[head[IDX_W-1:0]];
  assign placed_next = placed_set | (SLOTS'(1) << cur);

  always_comb begin
    low_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rel[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    live_or = '0;
    for (int i = 0; i < SLOTS; i++) begin
      seed_rel[i] = valid[i] && (rows[i] == '0);
      pop_rel[i]  = valid[i] && rows[i][cur] && ((rows[i] & ~placed_next) == '0);
      if (alive[i] && valid[i]) begin
        live_or = live_or | rows[i];
      end
    end
  end

  assign st.ovf_now       = overflow || (cnt == CNT_W'(CAP));
  assign st.rel_empty     = (rel == '0);
  assign st.queue_empty   = (head == tail);
  assign st.all_placed    = (placed == cnt);
  assign st.alive_changed = ((alive | live_or) != alive);
  assign st.emit_done     = ({1'b0, k} + CNT_W'(1) == cnt);
  assign st.out_free      = !out_valid || out_ready;

  // row store, queue and order payloads, no reset
  always_ff @(posedge clk) begin
    if (cmd.load && !st.ovf_now) begin
      rows[cnt[IDX_W-1:0]] <= in_mask;
    end
    if (cmd.mask) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid[i]) begin
          rows[i] <= rows[i] & valid & ~(SLOTS'(1) << i);
        end
      end
    end
    if (cmd.enq) begin
      queue[tail[IDX_W-1:0]] <= low_idx;
    end
    if (cmd.pop) begin
      order[placed[IDX_W-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      overflow   <= 1'b0;
      writers    <= '0;
      alive      <= '0;
      placed_set <= '0;
      placed     <= '0;
      head       <= '0;
      tail       <= '0;
      rel        <= '0;
      k          <= '0;
    end else begin
      if (cmd.load) begin
        if (st.ovf_now) begin
          overflow <= 1'b1;
        end else begin
          writers[cnt[IDX_W-1:0]] <= in_wout;
          cnt <= cnt + CNT_W'(1);
        end
      end
      if (cmd.mask) begin
        placed_set <= '0;
        placed     <= '0;
        head       <= '0;
        tail       <= '0;
      end
      if (cmd.seed) begin
        rel <= seed_rel;
      end
      if (cmd.enq) begin
        rel  <= rel & ~(SLOTS'(1) << low_idx);
        tail <= tail + CNT_W'(1);
      end
      if (cmd.pop) begin
        placed_set <= placed_next;
        placed     <= placed + CNT_W'(1);
        head       <= head + CNT_W'(1);
        rel        <= pop_rel;
      end
      if (cmd.live_init) begin
        alive <= writers & valid;
        k     <= '0;
      end
      if (cmd.live_step) begin
        alive <= alive | live_or;
      end
      if (cmd.emit_sort) begin
        k <= k + IDX_W'(1);
      end
      if (cmd.clear) begin
        cnt      <= '0;
        overflow <= 1'b0;
        writers  <= '0;
        alive    <= '0;
        head     <= '0;
        tail     <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sort || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sort) begin
      out_status <= ST_OK;
      out_idx    <= order[k];
      out_pos    <= k;
      out_culled <= !alive[order[k]];
      out_count  <= cnt;
      out_last   <= st.emit_done;
    end else if (cmd.emit_err) begin
      out_status <= overflow ? ST_OVERFLOW : ST_CYCLE;
      out_idx    <= '0;
      out_pos    <= '0;
      out_culled <= 1'b0;
      out_count  <= overflow ? cnt : placed;
      out_last   <= 1'b1;
    end
  end

endmodule

// ----- src/pass_topo_sort_and_cull.sv -----
// Top level of the pass topological sort and cull block.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
// Usage:
//   Slave channel: one request per render pass, in index order. tdata holds
//   the dependency mask, tuser the writes-output flag, tlast closes the graph.
//   Loading accepts one request per cycle; s_tready is high only while loading.
//   After tlast the block runs Kahn's sort (FIFO ready queue, ascending seed
//   and release order), then backward liveness from output writers, and
//   stalls input until the last result is in the output register.
//   Master channel: one result per pass in execution order, or a single
//   cycle result (status 1) or overflow result (status 2). tlast marks the
//   final result of a graph.
//   Sequence after tlast: mask and seed, per pass one enqueue, one pop and
//   one drain check, one more drain check and a final empty pop; then one
//   liveness init step, backward liveness sweeps until alive stops changing,
//   and one emit step per result.
//   A stalled receiver holds the output register and the emit sequencer.
//   Requests beyond MAX_PASSES (or 32) are dropped and flag overflow.
//   Reset (rst, synchronous) empties the graph and the output register.
module pass_topo_sort_and_cull
  import pts_pkg::*;
#(
  parameter int MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] dep_mask
  input  logic        s_tuser,   // [0] writes_output
  input  logic        s_tlast,   // last_pass
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] status, [6:2] pass_index,
                                 // [11:7] sort_position, [12] culled,
                                 // [18:13] sorted_count, [23:19] zero
  output logic        m_tlast    // last_result
);

  cmd_t             cmd;
  stat_t            st;
  status_t          o_status;
  logic [IDX_W-1:0] o_idx, o_pos;
  logic             o_culled;
  logic [CNT_W-1:0] o_count;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .st       (st),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  pts_datapath #(
    .MAX_PASSES (MAX_PASSES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mask    (s_tdata),
    .in_wout    (s_tuser),
    .out_ready  (m_tready),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_status (o_status),
    .out_idx    (o_idx),
    .out_pos    (o_pos),
    .out_culled (o_culled),
    .out_count  (o_count),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, o_count, o_culled, o_pos, o_idx, o_status};

endmodule
